// ===== sv/fsa_pkg.sv =====
// Shared constants, request codes and controller/datapath interface types.
package fsa_pkg;

   // Store geometry.
   localparam int MAX_FRAGMENTS = 16;
   localparam int MAX_FRAG_LEN  = 64;
   localparam int KEY_W         = 32;
   localparam int DEPTH         = MAX_FRAGMENTS * MAX_FRAG_LEN;
   localparam int FRAG_W        = $clog2(MAX_FRAGMENTS);
   localparam int OFF_W         = $clog2(MAX_FRAG_LEN);
   localparam int ADDR_W        = FRAG_W + OFF_W;

   // Field and register widths.
   localparam int IDX_W      = 16;
   localparam int QUO_W      = IDX_W - 1;
   localparam int STEP_W     = $clog2(QUO_W);
   localparam int CNT_W      = 5;
   localparam int SIZE_W     = 7;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int FILL_W     = $clog2(MAX_FRAG_LEN + 1);
   localparam int TOTAL_W    = 11;
   localparam int ACT_W      = 5;
   localparam int PROD_W     = ACT_W + SIZE_W;

   // Register reset values.
   localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(MAX_FRAGMENTS);
   localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(MAX_FRAG_LEN);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAGMENT_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAGMENT_SIZE  = 1'b1;

   // Request codes.
   typedef enum logic [1:0] {
      REQ_SET    = 2'd0,
      REQ_GET    = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_code_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_start;
      logic exec;
      logic fail;
      logic sweep;
      logic clear_resp;
   } fsa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_clear;
      logic is_neg;
      logic div_done;
      logic oob;
      logic sweep_last;
      logic cfg_clear;
   } fsa_status_type;

endpackage

// ===== sv/fsa_divider.sv =====
// Restoring divider that splits a flat index into fragment and offset, one bit a cycle.
module fsa_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [fsa_pkg::QUO_W-1:0]  dividend,
   input  logic [fsa_pkg::SIZE_W-1:0] divisor,
   output logic [fsa_pkg::QUO_W-1:0]  quotient,
   output logic [fsa_pkg::SIZE_W-1:0] remainder,
   output logic                       done
);

   logic [fsa_pkg::QUO_W-1:0]  quo_ff;
   logic [fsa_pkg::SIZE_W-1:0] rem_ff;
   logic [fsa_pkg::STEP_W-1:0] step_ff;
   logic                       run_ff;
   logic                       done_ff;
   logic [fsa_pkg::SIZE_W:0]   partial;
   logic [fsa_pkg::SIZE_W:0]   diff;

   always_comb begin
      partial = {rem_ff, quo_ff[fsa_pkg::QUO_W-1]};
      diff    = partial - {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            step_ff <= '0;
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            // A clear sign bit means the shifted remainder reached the divisor.
            if (!diff[fsa_pkg::SIZE_W]) begin
               rem_ff <= diff[fsa_pkg::SIZE_W-1:0];
               quo_ff <= {quo_ff[fsa_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_ff <= partial[fsa_pkg::SIZE_W-1:0];
               quo_ff <= {quo_ff[fsa_pkg::QUO_W-2:0], 1'b0};
            end
            step_ff <= step_ff + 1'b1;
            if (step_ff == fsa_pkg::STEP_W'(fsa_pkg::QUO_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ===== sv/fsa_datapath.sv =====
// Datapath: request latch, configuration, divider, cell memory, fill counters and result.
module fsa_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  fsa_pkg::fsa_cmd_type           cmd,
   output fsa_pkg::fsa_status_type        status,
   input  logic [1:0]                     req_type,
   input  logic [fsa_pkg::IDX_W-1:0]      req_cell_index,
   input  logic [fsa_pkg::KEY_W-1:0]      req_write_key,
   input  logic                           csr_we,
   input  logic [fsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fsa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           rsp_valid,
   output logic                           rsp_status,
   output logic [fsa_pkg::KEY_W-1:0]      rsp_read_value,
   output logic                           rsp_read_unused,
   output logic [fsa_pkg::TOTAL_W-1:0]    rsp_used_cells,
   output logic [fsa_pkg::ACT_W-1:0]      rsp_active_fragments,
   output logic [fsa_pkg::TOTAL_W-1:0]    rsp_allocated_cells
);

   // Latched request.
   fsa_pkg::req_code_type             req_ff;
   logic [fsa_pkg::IDX_W-1:0]         idx_ff;
   logic [fsa_pkg::KEY_W-1:0]         key_ff;

   // Configuration.
   logic [fsa_pkg::CNT_W-1:0]         count_ff;
   logic [fsa_pkg::SIZE_W-1:0]        size_ff;
   logic [fsa_pkg::CNT_W-1:0]         eff_count;
   logic [fsa_pkg::SIZE_W-1:0]        eff_size;

   // Divider results.
   logic [fsa_pkg::QUO_W-1:0]         quo;
   logic [fsa_pkg::SIZE_W-1:0]        rem;
   logic                              div_done;
   logic [fsa_pkg::FRAG_W-1:0]        frag;
   logic [fsa_pkg::ADDR_W-1:0]        addr;

   // Cell memory: valid bit on top of the key.
   logic [fsa_pkg::KEY_W:0]           mem [fsa_pkg::DEPTH];
   logic [fsa_pkg::KEY_W:0]           rd_ff;
   logic                              mem_we;
   logic [fsa_pkg::ADDR_W-1:0]        mem_waddr;
   logic [fsa_pkg::KEY_W:0]           mem_wdata;
   logic [fsa_pkg::ADDR_W-1:0]        sweep_ff;

   // Counters.
   logic [fsa_pkg::FILL_W-1:0]        fill_ff [fsa_pkg::MAX_FRAGMENTS];
   logic [fsa_pkg::FILL_W-1:0]        fill_in [fsa_pkg::MAX_FRAGMENTS];
   logic [fsa_pkg::FILL_W-1:0]        cur_fill;
   logic [fsa_pkg::TOTAL_W-1:0]       total_ff;
   logic [fsa_pkg::TOTAL_W-1:0]       total_in;
   logic [fsa_pkg::ACT_W-1:0]         active_ff;
   logic [fsa_pkg::ACT_W-1:0]         active_in;

   // Result.
   logic                              rsp_valid_ff;
   logic                              rsp_status_ff;
   logic [fsa_pkg::KEY_W-1:0]         rsp_value_ff;
   logic                              rsp_unused_ff;
   logic                              exec_status;
   logic [fsa_pkg::KEY_W-1:0]         exec_value;
   logic                              exec_unused;
   logic                              hit;
   logic [fsa_pkg::PROD_W-1:0]        alloc_prod;

   // Registers out of range are pinned to the nearest legal value.
   always_comb begin
      eff_count = count_ff;
      if (count_ff == '0) begin
         eff_count = fsa_pkg::CNT_W'(1);
      end else if (count_ff > fsa_pkg::CNT_W'(fsa_pkg::MAX_FRAGMENTS)) begin
         eff_count = fsa_pkg::CNT_W'(fsa_pkg::MAX_FRAGMENTS);
      end
      eff_size = size_ff;
      if (size_ff == '0) begin
         eff_size = fsa_pkg::SIZE_W'(1);
      end else if (size_ff > fsa_pkg::SIZE_W'(fsa_pkg::MAX_FRAG_LEN)) begin
         eff_size = fsa_pkg::SIZE_W'(fsa_pkg::MAX_FRAG_LEN);
      end
   end

   fsa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (idx_ff[fsa_pkg::QUO_W-1:0]),
      .divisor   (eff_size),
      .quotient  (quo),
      .remainder (rem),
      .done      (div_done)
   );

   assign frag = quo[fsa_pkg::FRAG_W-1:0];
   assign addr = {frag, rem[fsa_pkg::OFF_W-1:0]};

   always_comb begin
      status.is_clear   = (req_ff == fsa_pkg::REQ_CLEAR);
      status.is_neg     = idx_ff[fsa_pkg::IDX_W-1];
      status.div_done   = div_done;
      status.oob        = (quo >= fsa_pkg::QUO_W'(eff_count));
      status.sweep_last = (sweep_ff == fsa_pkg::ADDR_W'(fsa_pkg::DEPTH - 1));
      status.cfg_clear  = csr_we;
   end

   // Read-modify-write of one cell and its counters; a clearing-pass write zeroes all counters.
   always_comb begin
      hit         = rd_ff[fsa_pkg::KEY_W];
      cur_fill    = fill_ff[frag];
      fill_in     = fill_ff;
      total_in    = total_ff;
      active_in   = active_ff;
      mem_we      = 1'b0;
      mem_waddr   = addr;
      mem_wdata   = '0;
      exec_status = 1'b0;
      exec_value  = '0;
      exec_unused = 1'b0;
      if (cmd.sweep) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff;
         for (int i = 0; i < fsa_pkg::MAX_FRAGMENTS; i++) begin
            fill_in[i] = '0;
         end
         total_in  = '0;
         active_in = '0;
      end else if (cmd.exec) begin
         case (req_ff)
            fsa_pkg::REQ_SET: begin
               mem_we    = 1'b1;
               mem_wdata = {1'b1, key_ff};
               if (!hit) begin
                  fill_in[frag] = cur_fill + 1'b1;
                  total_in      = total_ff + 1'b1;
                  if (cur_fill == '0) begin
                     active_in = active_ff + 1'b1;
                  end
               end
            end
            fsa_pkg::REQ_GET: begin
               exec_value  = hit ? rd_ff[fsa_pkg::KEY_W-1:0] : '0;
               exec_unused = !hit;
            end
            fsa_pkg::REQ_DELETE: begin
               if (hit) begin
                  mem_we        = 1'b1;
                  fill_in[frag] = cur_fill - 1'b1;
                  total_in      = total_ff - 1'b1;
                  if (cur_fill == fsa_pkg::FILL_W'(1)) begin
                     active_in = active_ff - 1'b1;
                  end
               end else begin
                  exec_status = 1'b1;
               end
            end
            default: begin
               exec_status = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= fsa_pkg::req_code_type'(req_type);
         idx_ff <= req_cell_index;
         key_ff <= req_write_key;
      end
      if (cmd.exec) begin
         rsp_status_ff <= exec_status;
         rsp_value_ff  <= exec_value;
         rsp_unused_ff <= exec_unused;
      end else if (cmd.fail) begin
         rsp_status_ff <= 1'b1;
         rsp_value_ff  <= '0;
         rsp_unused_ff <= 1'b0;
      end else if (cmd.clear_resp) begin
         rsp_status_ff <= 1'b0;
         rsp_value_ff  <= '0;
         rsp_unused_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= fsa_pkg::COUNT_RESET;
         size_ff      <= fsa_pkg::SIZE_RESET;
         sweep_ff     <= '0;
         total_ff     <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < fsa_pkg::MAX_FRAGMENTS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index == fsa_pkg::CSR_FRAGMENT_COUNT) begin
               count_ff <= csr_wdata[fsa_pkg::CNT_W-1:0];
            end else begin
               size_ff <= csr_wdata[fsa_pkg::SIZE_W-1:0];
            end
         end
         // A register write restarts the clearing pass from the first cell.
         if (cmd.sweep && !csr_we) begin
            sweep_ff <= sweep_ff + 1'b1;
         end else begin
            sweep_ff <= '0;
         end
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         active_ff    <= active_in;
         rsp_valid_ff <= cmd.exec | cmd.fail | cmd.clear_resp;
      end
   end

   assign alloc_prod = fsa_pkg::PROD_W'(active_ff) * fsa_pkg::PROD_W'(eff_size);

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_read_value       = rsp_value_ff;
   assign rsp_read_unused      = rsp_unused_ff;
   assign rsp_used_cells       = total_ff;
   assign rsp_active_fragments = active_ff;
   assign rsp_allocated_cells  = alloc_prod[fsa_pkg::TOTAL_W-1:0];

endmodule

// ===== sv/fsa_ctrl.sv =====
// Controller state machine: request sequencing and clearing passes.
module fsa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output fsa_pkg::fsa_cmd_type    cmd,
   input  fsa_pkg::fsa_status_type status
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE,
      ST_EXEC,
      ST_FAIL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      resp_pend_ff;
   logic      resp_pend_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      resp_pend_in = resp_pend_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               cmd.clear_resp = resp_pend_ff;
               resp_pend_in   = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_clear) begin
               resp_pend_in = 1'b1;
               state_in     = ST_CLEAR;
            end else if (status.is_neg) begin
               state_in = ST_FAIL;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = status.oob ? ST_FAIL : ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FAIL: begin
            cmd.fail = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A register write clears the store without a result of its own.
      if (status.cfg_clear) begin
         cmd.load       = 1'b0;
         cmd.clear_resp = 1'b0;
         state_in       = ST_CLEAR;
         if (state_ff != ST_CLEAR) begin
            resp_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         resp_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resp_pend_ff <= resp_pend_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/fragmented_sparse_array.sv =====
// Top level of the fragmented sparse array: controller plus datapath.
//
//   channel   handshake            payload
//   request   start / busy         req_type, req_cell_index, req_write_key
//   result    rsp_valid (strobe)   rsp_status, rsp_read_value, rsp_read_unused,
//                                  rsp_used_cells, rsp_active_fragments,
//                                  rsp_allocated_cells
//   config    csr_we               csr_index, csr_wdata
//
// A set, get or delete beat strobes its result after decode, a bit-serial divide for
// fragment and offset, a registered memory read and an update; busy falls with the
// strobe. A negative index skips the divide and strobes its failure from the fail
// state. Reset, a clear-all beat and each register write run a clearing pass over
// all 1024 cells with busy high; a clear-all result strobes at the end of the pass.
// The receiver cannot stall.
module fragmented_sparse_array (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_type,
   input  logic signed [fsa_pkg::IDX_W-1:0]      req_cell_index,
   input  logic signed [fsa_pkg::KEY_W-1:0]      req_write_key,
   // Result channel.
   output logic                                  rsp_valid,
   output logic                                  rsp_status,
   output logic signed [fsa_pkg::KEY_W-1:0]      rsp_read_value,
   output logic                                  rsp_read_unused,
   output logic [fsa_pkg::TOTAL_W-1:0]           rsp_used_cells,
   output logic [fsa_pkg::ACT_W-1:0]             rsp_active_fragments,
   output logic [fsa_pkg::TOTAL_W-1:0]           rsp_allocated_cells,
   // Configuration port.
   input  logic                                  csr_we,
   input  logic [fsa_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fsa_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // The controller only sequences; all storage and arithmetic live in the datapath.
   fsa_pkg::fsa_cmd_type    cmd;
   fsa_pkg::fsa_status_type status;

   fsa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // The datapath keeps the valid bit beside each key in one memory word, so a
   // clearing pass resets both and a never-written cell always reads as unused.
   fsa_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_type             (req_type),
      .req_cell_index       (req_cell_index),
      .req_write_key        (req_write_key),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_read_value       (rsp_read_value),
      .rsp_read_unused      (rsp_read_unused),
      .rsp_used_cells       (rsp_used_cells),
      .rsp_active_fragments (rsp_active_fragments),
      .rsp_allocated_cells  (rsp_allocated_cells)
   );

endmodule
